// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the LCA engine.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lca assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lca assertion failed");

`endif

// ===== hdl/lca_pkg.sv =====
// Types and constants of the LCA engine.
// No dependencies.
package lca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int KIND_W  = 2;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    localparam kind_t KIND_LOAD  = 2'd0;
    localparam kind_t KIND_BUILD = 2'd1;
    localparam kind_t KIND_QUERY = 2'd2;
    localparam kind_t KIND_NONE  = 2'd3;

    localparam node_t NODE_COUNT_RESET = 10'd1023;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MOD,
        S_LOAD,
        S_BLD_INIT,
        S_BLD_RD1,
        S_BLD_RD2,
        S_BLD_WR,
        S_Q_DX,
        S_Q_DY,
        S_Q_DIFF,
        S_Q_LIFT,
        S_Q_LIFTW,
        S_Q_CHK,
        S_Q_JRD,
        S_Q_JCMP,
        S_Q_FIN,
        S_Q_FINW,
        S_DONE
    } state_t;

endpackage

// ===== hdl/lca_in_if.sv =====
// Request channel of the LCA engine: valid/ready plus one request word.
// Depends on lca_pkg.
interface lca_in_if;
    import lca_pkg::*;

    logic   valid;
    logic   ready;
    kind_t  kind;
    node_t  node_a;
    node_t  node_b;
    depth_t depth_in;

    modport source (output valid, output kind, output node_a, output node_b,
                    output depth_in, input ready);
    modport sink   (input valid, input kind, input node_a, input node_b,
                    input depth_in, output ready);
endinterface

// ===== hdl/lca_out_if.sv =====
// Result channel of the LCA engine: valid/ready plus one result word.
// Depends on lca_pkg.
interface lca_out_if;
    import lca_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind_done;
    node_t ancestor;

    modport source (output valid, output kind_done, output ancestor, input ready);
    modport sink   (input valid, input kind_done, input ancestor, output ready);
endinterface

// ===== hdl/lowest_common_ancestor_engine_unit.sv =====
// Binary-lifting LCA engine; depth store and ancestor table in sync RAMs, one word at a time.
// A query does one table read per lift step (set bit of the depth difference) and per jump
// step (level); a build fills levels 1 to LEVELS-1 of nodes 1 to min(node_count, MAX_NODES-1).
// The next word is accepted in the cycle after the result is loaded; a stalled result
// holds the input. Nodes at or above MAX_NODES (if below 1024) are reduced modulo MAX_NODES.
// Async reset clears control and node_count to 1023; RAMs not.
module lowest_common_ancestor_engine_unit #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [lca_pkg::NODE_W-1:0] cfg_wdata,
    lca_in_if.sink                 req,
    lca_out_if.source              rsp
);
    import lca_pkg::*;

    localparam int AW        = $clog2(MAX_NODES);
    localparam int LW        = $clog2(LEVELS);
    localparam int TAW       = AW + LW;
    localparam int TAB_DEPTH = MAX_NODES * (2 ** LW);

    state_t state_reg, state_next;

    kind_t  kind_reg, kind_next;
    node_t  a_reg, a_next;
    node_t  b_reg, b_next;
    depth_t d_reg, d_next;
    node_t  node_count_reg, node_count_next;
    node_t  x_reg, x_next;
    node_t  y_reg, y_next;
    depth_t dx_reg, dx_next;
    logic [LEVELS-1:0] diff_reg, diff_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    node_t  idx_reg, idx_next;
    node_t  last_reg, last_next;
    node_t  res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    kind_t  out_kind_reg, out_kind_next;
    node_t  out_anc_reg, out_anc_next;

    // memories
    logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
    logic [NODE_W-1:0]  tab_mem [TAB_DEPTH];

    logic           dep_we;
    logic [AW-1:0]  dep_waddr;
    logic [AW-1:0]  dep_raddr;
    node_t          dep_rnode;
    depth_t         dep_rd_reg;
    logic           dep_zero_reg;

    logic           tab_we;
    logic [TAW-1:0] tab_waddr;
    node_t          tab_wdata;
    logic [TAW-1:0] tab_raddr_a;
    logic [TAW-1:0] tab_raddr_b;
    node_t          tab_rnode_a;
    node_t          tab_rnode_b;
    node_t          tab_rd_a_reg;
    node_t          tab_rd_b_reg;
    logic           tab_zero_a_reg;
    logic           tab_zero_b_reg;

    // node zero is the sentinel: all reads of it answer zero
    depth_t dep_val;
    node_t  tab_a_val;
    node_t  tab_b_val;

    assign dep_val   = dep_zero_reg   ? '0 : dep_rd_reg;
    assign tab_a_val = tab_zero_a_reg ? '0 : tab_rd_a_reg;
    assign tab_b_val = tab_zero_b_reg ? '0 : tab_rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_waddr] <= d_reg;
        end
        dep_rd_reg   <= dep_mem[dep_raddr];
        dep_zero_reg <= (dep_rnode == '0);
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_rd_a_reg   <= tab_mem[tab_raddr_a];
        tab_rd_b_reg   <= tab_mem[tab_raddr_b];
        tab_zero_a_reg <= (tab_rnode_a == '0);
        tab_zero_b_reg <= (tab_rnode_b == '0);
    end

    // shared conditions
    logic          req_acc;
    logic          out_free;
    logic          a_big;
    logic          b_big;
    logic          lvl_top;
    logic          lvl_bot;
    logic [LW-1:0] lvl_dec;
    node_t         last_calc;
    logic          swap;
    depth_t        diff10;

    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign a_big     = 32'(a_reg) >= MAX_NODES;
    assign b_big     = 32'(b_reg) >= MAX_NODES;
    assign lvl_top   = (lvl_reg == LW'(LEVELS - 1));
    assign lvl_bot   = (lvl_reg == '0);
    assign lvl_dec   = lvl_reg - LW'(1);
    assign last_calc = (32'(node_count_reg) > MAX_NODES - 1) ?
                       NODE_W'(MAX_NODES - 1) : node_count_reg;
    assign swap      = dep_val > dx_reg;
    assign diff10    = swap ? (dep_val - dx_reg) : (dx_reg - dep_val);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc && req.kind != KIND_NONE)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!a_big && !b_big)
                begin
                    case (kind_reg)
                        KIND_LOAD:  state_next = S_LOAD;
                        KIND_BUILD: state_next = S_BLD_INIT;
                        default:    state_next = S_Q_DX;
                    endcase
                end
            end
            S_LOAD:     state_next = S_DONE;
            S_BLD_INIT: state_next = (last_calc == '0) ? S_DONE : S_BLD_RD1;
            S_BLD_RD1:  state_next = S_BLD_RD2;
            S_BLD_RD2:  state_next = S_BLD_WR;
            S_BLD_WR:
            begin
                if (idx_reg == last_reg && lvl_top)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BLD_RD1;
                end
            end
            S_Q_DX:     state_next = S_Q_DY;
            S_Q_DY:     state_next = S_Q_DIFF;
            S_Q_DIFF:   state_next = S_Q_LIFT;
            S_Q_LIFT:
            begin
                if (diff_reg[lvl_reg])
                begin
                    state_next = S_Q_LIFTW;
                end
                else if (lvl_top)
                begin
                    state_next = S_Q_CHK;
                end
            end
            S_Q_LIFTW:  state_next = lvl_top ? S_Q_CHK : S_Q_LIFT;
            S_Q_CHK:    state_next = (x_reg == y_reg) ? S_DONE : S_Q_JRD;
            S_Q_JRD:    state_next = S_Q_JCMP;
            S_Q_JCMP:   state_next = lvl_bot ? S_Q_FIN : S_Q_JRD;
            S_Q_FIN:    state_next = S_Q_FINW;
            S_Q_FINW:   state_next = S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs: handshake and memory ports
    always_comb
    begin
        req.ready   = (state_reg == S_IDLE);
        dep_we      = 1'b0;
        dep_waddr   = AW'(a_reg);
        dep_raddr   = AW'(a_reg);
        dep_rnode   = a_reg;
        tab_we      = 1'b0;
        tab_waddr   = {AW'(idx_reg), lvl_reg};
        tab_wdata   = tab_a_val;
        tab_raddr_a = {AW'(x_reg), lvl_reg};
        tab_raddr_b = {AW'(y_reg), lvl_reg};
        tab_rnode_a = x_reg;
        tab_rnode_b = y_reg;
        case (state_reg)
            S_LOAD:
            begin
                dep_we    = (a_reg != '0);
                tab_we    = (a_reg != '0);
                tab_waddr = {AW'(a_reg), LW'(0)};
                tab_wdata = b_reg;
            end
            S_BLD_RD1:
            begin
                tab_raddr_a = {AW'(idx_reg), lvl_dec};
                tab_rnode_a = idx_reg;
            end
            S_BLD_RD2:
            begin
                tab_raddr_a = {AW'(tab_a_val), lvl_dec};
                tab_rnode_a = tab_a_val;
            end
            S_BLD_WR:
            begin
                tab_we = 1'b1;
            end
            S_Q_DY:
            begin
                dep_raddr = AW'(b_reg);
                dep_rnode = b_reg;
            end
            S_Q_FIN:
            begin
                tab_raddr_a = {AW'(x_reg), LW'(0)};
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind_done = out_kind_reg;
    assign rsp.ancestor  = out_anc_reg;

    // datapath
    always_comb
    begin
        kind_next       = kind_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        d_next          = d_reg;
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        dx_next         = dx_reg;
        diff_next       = diff_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_anc_next    = out_anc_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    kind_next = req.kind;
                    a_next    = req.node_a;
                    b_next    = req.node_b;
                    d_next    = req.depth_in;
                    res_next  = '0;
                end
            end
            S_MOD:
            begin
                if (a_big)
                begin
                    a_next = a_reg - NODE_W'(MAX_NODES);
                end
                if (b_big)
                begin
                    b_next = b_reg - NODE_W'(MAX_NODES);
                end
            end
            S_BLD_INIT:
            begin
                last_next = last_calc;
                idx_next  = NODE_W'(1);
                lvl_next  = LW'(1);
            end
            S_BLD_WR:
            begin
                if (idx_reg == last_reg)
                begin
                    idx_next = NODE_W'(1);
                    lvl_next = lvl_reg + LW'(1);
                end
                else
                begin
                    idx_next = idx_reg + NODE_W'(1);
                end
            end
            S_Q_DY:
            begin
                dx_next = dep_val;
            end
            S_Q_DIFF:
            begin
                x_next    = swap ? b_reg : a_reg;
                y_next    = swap ? a_reg : b_reg;
                diff_next = LEVELS'(diff10);
                lvl_next  = '0;
            end
            S_Q_LIFT:
            begin
                if (!diff_reg[lvl_reg] && !lvl_top)
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            S_Q_LIFTW:
            begin
                x_next = tab_a_val;
                if (!lvl_top)
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            S_Q_CHK:
            begin
                res_next = x_reg;
                lvl_next = LW'(LEVELS - 1);
            end
            S_Q_JCMP:
            begin
                if (tab_a_val != tab_b_val)
                begin
                    x_next = tab_a_val;
                    y_next = tab_b_val;
                end
                if (!lvl_bot)
                begin
                    lvl_next = lvl_dec;
                end
            end
            S_Q_FINW:
            begin
                res_next = tab_a_val;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_anc_next   = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        d_reg        <= d_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dx_reg       <= dx_next;
        diff_reg     <= diff_next;
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        res_reg      <= res_next;
        out_kind_reg <= out_kind_next;
        out_anc_reg  <= out_anc_next;
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_starts, req_acc && req.kind != KIND_NONE, state_reg == S_MOD)
    `ASSERT_NEXT(a_done_loads_word, state_reg == S_DONE && out_free,
                 out_valid_reg && state_reg == S_IDLE)
    `ASSERT_IMP(a_build_idx_range, state_reg == S_BLD_WR,
                idx_reg != '0 && idx_reg <= last_reg && lvl_reg != '0)
    `ASSERT_IMP(a_query_no_write, state_reg == S_Q_JRD || state_reg == S_Q_JCMP ||
                state_reg == S_Q_LIFT || state_reg == S_Q_LIFTW, !tab_we && !dep_we)

endmodule

// ===== tb/sv/lca_tracker_pkg.sv =====
// Scoreboard for the LCA engine testbench: keeps its own copy of the depth store,
// ancestor table and node count, predicts each result word and checks what comes back.
// Depends on lca_pkg.
package lca_tracker_pkg;
    import lca_pkg::*;

    localparam int TREE_NODES  = 1024;
    localparam int TREE_LEVELS = 10;

    typedef struct packed {
        kind_t kind;
        node_t ancestor;
    } answer_t;

    class ancestor_tracker;
        depth_t  depth_mem [TREE_NODES];
        bit      depth_known [TREE_NODES];
        node_t   jump_mem [TREE_NODES][TREE_LEVELS];
        bit      jump_known [TREE_NODES][TREE_LEVELS];
        node_t   node_count;
        answer_t pending [$];
        int      errors;
        int      checked;

        function new();
            for (int n = 0; n < TREE_NODES; n++)
            begin
                depth_mem[n] = '0;
                depth_known[n] = 1'b0;
                for (int k = 0; k < TREE_LEVELS; k++)
                begin
                    jump_mem[n][k] = '0;
                    jump_known[n][k] = (n == 0);
                end
            end
            node_count = NODE_COUNT_RESET;
            errors = 0;
            checked = 0;
        endfunction

        // blind is set when the walk touches an entry never written
        function node_t common_ancestor(node_t a, node_t b, output bit blind);
            node_t  x;
            node_t  y;
            depth_t diff;
            blind = !depth_known[a] || !depth_known[b];
            if (depth_mem[b] > depth_mem[a])
            begin
                x = b;
                y = a;
            end
            else
            begin
                x = a;
                y = b;
            end
            diff = depth_mem[x] - depth_mem[y];
            for (int k = 0; k < TREE_LEVELS; k++)
            begin
                if (diff[k])
                begin
                    blind |= !jump_known[x][k];
                    x = jump_mem[x][k];
                end
            end
            if (x == y)
                return x;
            for (int k = TREE_LEVELS - 1; k >= 0; k--)
            begin
                blind |= !jump_known[x][k] || !jump_known[y][k];
                if (jump_mem[x][k] != jump_mem[y][k])
                begin
                    x = jump_mem[x][k];
                    y = jump_mem[y][k];
                end
            end
            blind |= !jump_known[x][0];
            return jump_mem[x][0];
        endfunction

        // Runs the table fill; keeps the result only when commit is set.
        function bit fill_levels(bit commit);
            node_t mem [TREE_NODES][TREE_LEVELS];
            bit    known [TREE_NODES][TREE_LEVELS];
            int    last;
            node_t p;
            bit    blind;
            mem = jump_mem;
            known = jump_known;
            last = (node_count > TREE_NODES - 1) ? TREE_NODES - 1 : node_count;
            blind = 1'b0;
            for (int k = 1; k < TREE_LEVELS; k++)
            begin
                for (int i = 1; i <= last; i++)
                begin
                    p = mem[i][k-1];
                    blind |= !known[i][k-1] || !known[p][k-1];
                    mem[i][k] = mem[p][k-1];
                    known[i][k] = 1'b1;
                end
            end
            if (commit)
            begin
                jump_mem = mem;
                jump_known = known;
            end
            return blind;
        endfunction

        function void note_request(kind_t kind, node_t a, node_t b, depth_t d);
            answer_t word;
            bit      blind;
            word.kind = kind;
            word.ancestor = '0;
            case (kind)
                KIND_LOAD:
                begin
                    if (a != 0)
                    begin
                        depth_mem[a] = d;
                        depth_known[a] = 1'b1;
                        jump_mem[a][0] = b;
                        jump_known[a][0] = 1'b1;
                    end
                end
                KIND_BUILD:
                    void'(fill_levels(1'b1));
                KIND_QUERY:
                    word.ancestor = common_ancestor(a, b, blind);
                default:
                    return;
            endcase
            pending = {pending, word};
        endfunction

        function void check_result(kind_t kind, node_t ancestor);
            answer_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual kind %0d ancestor %0d",
                         $time, kind, ancestor);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (kind !== want.kind)
            begin
                errors++;
                $display("%0t: kind_done mismatch, expected %0d actual %0d",
                         $time, want.kind, kind);
            end
            if (ancestor !== want.ancestor)
            begin
                errors++;
                $display("%0t: ancestor mismatch, expected %0d actual %0d",
                         $time, want.ancestor, ancestor);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/lowest_common_ancestor_engine_unit_tb.sv =====
// Testbench for lowest_common_ancestor_engine_unit: loads random forests, builds the
// ancestor table and checks query answers under random stalls on both channels.
// Depends on lca_pkg, lca_in_if, lca_out_if and lca_tracker_pkg.
module lowest_common_ancestor_engine_unit_tb;
    import lca_pkg::*;
    import lca_tracker_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_STALL    = 400;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    node_t cfg_wdata;

    lca_in_if  req ();
    lca_out_if rsp ();

    lowest_common_ancestor_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    ancestor_tracker tracker;
    bit gaps_on;
    bit long_stall_req;
    bit send_calm;
    int send_calm_left;
    int cycle_count;
    int loads_sent;
    int builds_sent;
    int queries_sent;
    int settings_used;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            tracker.check_result(rsp.kind_done, rsp.ancestor);
    end

    // result side: random back-pressure, plus one long counted hold on request
    initial
    begin
        int  stall_left;
        int  calm_left;
        bit  calm;
        rsp.ready = 1'b0;
        stall_left = 0;
        calm_left = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm_left = $urandom_range(8, 40);
                calm = ($urandom_range(0, 2) == 0);
            end
            calm_left--;
            if (stall_left == 0 && long_stall_req)
            begin
                stall_left = LONG_STALL;
                long_stall_req = 1'b0;
            end
            else if (stall_left == 0 && gaps_on && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left != 0)
            begin
                rsp.ready = 1'b0;
                stall_left--;
            end
            else
                rsp.ready = 1'b1;
        end
    end

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            req.valid = 1'b0;
        end
    endtask

    task automatic send_word(kind_t kind, node_t a, node_t b, depth_t d);
        if (send_calm_left == 0)
        begin
            send_calm_left = $urandom_range(8, 40);
            send_calm = ($urandom_range(0, 2) == 0);
        end
        send_calm_left--;
        if (gaps_on && !send_calm && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 11));
        @(negedge clk);
        req.valid = 1'b1;
        req.kind = kind;
        req.node_a = a;
        req.node_b = b;
        req.depth_in = d;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        tracker.note_request(kind, a, b, d);
        case (kind)
            KIND_LOAD:  loads_sent++;
            KIND_BUILD: builds_sent++;
            KIND_QUERY: queries_sent++;
            default:    ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        req.valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(node_t v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.node_count = v;
        settings_used++;
    endtask

    // falls back to a node against itself when the pair would hit unwritten rows
    task automatic ask(node_t a, node_t b);
        bit blind;
        void'(tracker.common_ancestor(a, b, blind));
        if (blind)
            b = a;
        send_word(KIND_QUERY, a, b, DEPTH_W'($urandom));
    endtask

    task automatic build_table();
        if (!tracker.fill_levels(1'b0))
            send_word(KIND_BUILD, NODE_W'($urandom), NODE_W'($urandom), DEPTH_W'($urandom));
    endtask

    task automatic plant_tree(int n, int root_odds);
        int     parent;
        depth_t d;
        for (int i = 1; i <= n; i++)
        begin
            if (i == 1 || $urandom_range(0, root_odds) == 0)
                parent = 0;
            else if ($urandom_range(0, 1) == 0)
                parent = i - 1;
            else if ($urandom_range(0, 1) == 0)
                parent = i - 1 - $urandom_range(0, (i - 2 < 3) ? i - 2 : 3);
            else
                parent = $urandom_range(1, i - 1);
            d = (parent == 0) ? '0 : DEPTH_W'(tracker.depth_mem[parent] + 1);
            if ($urandom_range(0, 31) == 0)
                d = DEPTH_W'($urandom);
            send_word(KIND_LOAD, NODE_W'(i), NODE_W'(parent), d);
        end
    endtask

    task automatic churn(int n, int ops);
        node_t  a;
        node_t  b;
        depth_t d;
        bit     blind;
        int     pick;
        for (int j = 0; j < ops; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    a = NODE_W'($urandom_range(1, n));
                    b = NODE_W'($urandom_range(1, n));
                    void'(tracker.common_ancestor(a, b, blind));
                    if (!blind)
                        break;
                end
                ask(a, b);
            end
            else if (pick < 80)
            begin
                // reparent inside the active range, table left stale until next build
                a = NODE_W'($urandom_range(1, n));
                b = NODE_W'($urandom_range(0, n));
                d = (b == 0) ? '0 : DEPTH_W'(tracker.depth_mem[b] + 1);
                if ($urandom_range(0, 7) == 0)
                    d = DEPTH_W'($urandom);
                send_word(KIND_LOAD, a, b, d);
            end
            else if (pick < 88)
            begin
                if (n < 100)
                    build_table();
                else
                    j--;
            end
            else if (pick < 94)
            begin
                a = (n >= 1023 || $urandom_range(0, 1) == 0) ? '0 :
                    NODE_W'($urandom_range(n + 1, 1023));
                send_word(KIND_LOAD, a, NODE_W'($urandom), DEPTH_W'($urandom));
            end
            else
            begin
                send_word(KIND_NONE, NODE_W'($urandom), NODE_W'($urandom),
                          DEPTH_W'($urandom));
                j--;
            end
        end
    endtask

    task automatic run_phase(int n, int ops, int root_odds);
        settle();
        set_count(NODE_W'(n));
        plant_tree(n, root_odds);
        build_table();
        churn(n, ops);
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.kind = KIND_LOAD;
        req.node_a = '0;
        req.node_b = '0;
        req.depth_in = '0;
        gaps_on = 1'b1;
        long_stall_req = 1'b0;
        send_calm = 1'b0;
        send_calm_left = 0;
        loads_sent = 0;
        builds_sent = 0;
        queries_sent = 0;
        settings_used = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(KIND_NONE, 10'd1023, 10'd1023, 10'd1023);
        send_word(KIND_LOAD, 10'd0, 10'd1023, 10'd1023);
        send_word(KIND_LOAD, 10'd1, 10'd0, 10'd0);
        send_word(KIND_LOAD, 10'd1023, 10'd1, 10'd1);
        send_word(KIND_LOAD, 10'd512, 10'd1023, 10'd2);
        send_word(KIND_LOAD, 10'd2, 10'd1, 10'd1);
        // queries ahead of any build
        ask(10'd512, 10'd1023);
        ask(10'd1023, 10'd1023);
        ask(10'd2, 10'd1);
        ask(10'd1, 10'd2);
        settle();
        set_count(10'd0);
        build_table();
        settle();
        set_count(10'd1);
        build_table();
        ask(10'd1, 10'd1);
        send_word(KIND_LOAD, 10'd3, 10'd2, 10'd1023);
        send_word(KIND_LOAD, 10'd4, 10'd0, 10'd0);
        settle();
        set_count(10'd4);
        build_table();
        ask(10'd3, 10'd1);
        ask(10'd2, 10'd4);
        ask(10'd3, 10'd2);
        ask(10'd4, 10'd3);
        ask(10'd2, 10'd2);

        run_phase(1, 20, 20);
        run_phase(2, 30, 20);
        run_phase(9, 40, 20);
        run_phase(33, 30, 20);
        long_stall_req = 1'b1;
        churn(33, 30);
        drain();
        churn(33, 30);
        run_phase(64, 60, 20);
        run_phase(200, 60, 100);
        gaps_on = 1'b0;
        run_phase(17, 60, 20);
        settle();

        $display("Covered %0d loads, %0d builds and %0d queries over %0d node-count settings,",
                 loads_sent, builds_sent, queries_sent, settings_used);
        $display("with %0d result words checked and %0d mismatches.",
                 tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lca_pkg.sv
hdl/lca_in_if.sv
hdl/lca_out_if.sv
hdl/lowest_common_ancestor_engine_unit.sv
tb/sv/lca_tracker_pkg.sv
tb/sv/lowest_common_ancestor_engine_unit_tb.sv
